/* hw/rtl/interpreter_integer_alu_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the interpreter integer ALU unit
// Shared immediate-implication and next-cycle-implication property shells.
// ----------------------------------------------------------------------------
`ifndef INTERPRETER_INTEGER_ALU_UNIT_DEFINES_SVH
`define INTERPRETER_INTEGER_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIAU_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IIAU_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/iiau_pkg.sv */
// ----------------------------------------------------------------------------
// iiau_pkg
// Types, codes and constants shared by the integer ALU unit modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iiau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_W           = 4;
    localparam int VAL_W          = 32;
    localparam int MUL_DIGIT      = 8;
    localparam int S_TDATA_W      = 72;  // op + two values, padded to bytes
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 32;
    localparam int M_TUSER_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_POW = 4'd5,
        OP_EQ  = 4'd6,
        OP_NE  = 4'd7,
        OP_GT  = 4'd8,
        OP_GE  = 4'd9,
        OP_LT  = 4'd10,
        OP_LE  = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        MSRC_AB,
        MSRC_ACC_SQ,
        MSRC_SQ_SQ
    } mul_src_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_DIV,
        ST_POW_CHK,
        ST_POW_ACC,
        ST_POW_SQ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_load;
        mul_src_t mul_src;
        logic     mul_step;
        logic     div_load;
        logic     div_step;
        logic     pow_init;
        logic     acc_write;
        logic     sq_write;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            div_zero;
        logic            div_last;
        logic            mul_idle;
        logic            ex_neg;
        logic            ex_zero;
        logic            ex_bit0;
        logic            ex_last;
    } ctrl_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/iiau_ctrl.sv */
// ----------------------------------------------------------------------------
// iiau_ctrl
// Sequencer for the integer ALU: dispatches each beat to the multiply,
// divide or power loop or straight to the result, and drives the stream handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iiau_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    input  iiau_pkg::ctrl_stat_t stat,
    output iiau_pkg::ctrl_cmd_t  cmd
);
    import iiau_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                unique case (stat.op) inside
                    OP_MUL: begin
                        state_next = ST_MUL;
                    end
                    OP_DIV, OP_MOD: begin
                        state_next = stat.div_zero ? ST_DONE : ST_DIV;
                    end
                    OP_POW: begin
                        state_next = stat.ex_neg ? ST_DONE : ST_POW_CHK;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MUL: begin
                if (stat.mul_idle) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (stat.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_POW_CHK: begin
                if (stat.ex_zero) begin
                    state_next = ST_DONE;
                end else if (stat.ex_bit0) begin
                    state_next = ST_POW_ACC;
                end else begin
                    state_next = ST_POW_SQ;
                end
            end
            ST_POW_ACC: begin
                if (stat.mul_idle) begin
                    state_next = stat.ex_last ? ST_DONE : ST_POW_SQ;
                end
            end
            ST_POW_SQ: begin
                if (stat.mul_idle) begin
                    state_next = ST_POW_CHK;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        cmd         = '0;
        cmd.mul_src = MSRC_AB;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_in = s_tvalid;
            end
            ST_START: begin
                unique case (stat.op) inside
                    OP_MUL: begin
                        cmd.mul_load = 1'b1;
                    end
                    OP_DIV, OP_MOD: begin
                        cmd.div_load = !stat.div_zero;
                    end
                    OP_POW: begin
                        cmd.pow_init = !stat.ex_neg;
                    end
                    default: begin
                    end
                endcase
            end
            ST_MUL: begin
                cmd.mul_step = !stat.mul_idle;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_POW_CHK: begin
                if (!stat.ex_zero) begin
                    cmd.mul_load = 1'b1;
                    cmd.mul_src  = stat.ex_bit0 ? MSRC_ACC_SQ : MSRC_SQ_SQ;
                end
            end
            ST_POW_ACC: begin
                if (stat.mul_idle) begin
                    cmd.acc_write = 1'b1;
                    cmd.mul_load  = !stat.ex_last;
                    cmd.mul_src   = MSRC_SQ_SQ;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_POW_SQ: begin
                if (stat.mul_idle) begin
                    cmd.sq_write = 1'b1;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_DONE: begin
                cmd.out_load = out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/iiau_dp.sv */
// ----------------------------------------------------------------------------
// iiau_dp
// Datapath of the integer ALU: operand registers, a digit-serial multiplier,
// a radix-2 restoring divider, the power registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iiau_dp #(
    parameter int DATA_WIDTH = iiau_pkg::DATA_WIDTH_DEF
) (
    input  wire                          aclk,
    input  wire  [iiau_pkg::OP_W-1:0]    s_op,
    input  wire  [iiau_pkg::VAL_W-1:0]   s_left_value,
    input  wire                          s_left_is_bool,
    input  wire  [iiau_pkg::VAL_W-1:0]   s_right_value,
    input  wire                          s_right_is_bool,
    input  iiau_pkg::ctrl_cmd_t          cmd,
    output iiau_pkg::ctrl_stat_t         stat,
    output logic [iiau_pkg::VAL_W-1:0]   m_result_value,
    output logic                         m_result_is_bool,
    output logic                         m_error
);
    import iiau_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    logic [OP_W-1:0]  op_reg;
    logic [W-1:0]     a_reg, b_reg;
    logic             lb_reg, rb_reg;
    logic [W-1:0]     mcand_reg, mplier_reg, prod_reg;
    logic [W-1:0]     acc_reg, sq_reg, ex_reg;
    logic [W-1:0]     rem_reg, quo_reg, dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VAL_W-1:0] res_out_reg;
    logic             bool_out_reg, err_out_reg;

    logic [W+MUL_DIGIT-1:0] pp_full;
    logic [W:0]             trial;
    logic [W-1:0]           a_mag, b_mag;
    logic [W-1:0]           ca, cb;
    logic                   lt_ab, lt_ba;
    logic [W-1:0]           res_w;
    logic                   res_bool, res_err;

    assign pp_full = {{MUL_DIGIT{1'b0}}, mcand_reg}
                   * {{W{1'b0}}, mplier_reg[MUL_DIGIT-1:0]};
    assign trial   = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};
    assign a_mag   = a_reg[W-1] ? (~a_reg + 1'b1) : a_reg;
    assign b_mag   = b_reg[W-1] ? (~b_reg + 1'b1) : b_reg;

    assign stat.op       = op_reg;
    assign stat.div_zero = (b_reg == '0);
    assign stat.div_last = (cnt_reg == CNT_LAST);
    assign stat.mul_idle = (mplier_reg == '0);
    assign stat.ex_neg   = b_reg[W-1];
    assign stat.ex_zero  = (ex_reg == '0);
    assign stat.ex_bit0  = ex_reg[0];
    assign stat.ex_last  = (ex_reg[W-1:1] == '0);

    // Operands are sign-extended or truncated to the working width.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg <= s_op;
            a_reg  <= W'($signed(s_left_value));
            b_reg  <= W'($signed(s_right_value));
            lb_reg <= s_left_is_bool;
            rb_reg <= s_right_is_bool;
        end
    end

    // Multiplier: one digit of the multiplier operand per cycle, low half kept.
    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            prod_reg <= '0;
            case (cmd.mul_src)
                MSRC_ACC_SQ: begin
                    mcand_reg  <= sq_reg;
                    mplier_reg <= acc_reg;
                end
                MSRC_SQ_SQ: begin
                    mcand_reg  <= sq_reg;
                    mplier_reg <= sq_reg;
                end
                default: begin
                    mcand_reg  <= a_reg;
                    mplier_reg <= b_reg;
                end
            endcase
        end else if (cmd.mul_step) begin
            prod_reg   <= prod_reg + pp_full[W-1:0];
            mcand_reg  <= mcand_reg << MUL_DIGIT;
            mplier_reg <= mplier_reg >> MUL_DIGIT;
        end
    end

    // Square-and-multiply registers.
    always_ff @(posedge aclk) begin
        if (cmd.pow_init) begin
            acc_reg <= W'(1);
            sq_reg  <= a_reg;
            ex_reg  <= b_reg;
        end else begin
            if (cmd.acc_write) begin
                acc_reg <= prod_reg;
            end
            if (cmd.sq_write) begin
                sq_reg <= prod_reg;
                ex_reg <= ex_reg >> 1;
            end
        end
    end

    // Restoring divider on magnitudes, one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= '0;
            quo_reg <= a_mag;
            dvs_reg <= b_mag;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (!trial[W]) begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    // Boolean operands count as one when nonzero in comparisons.
    assign ca    = lb_reg ? {{(W-1){1'b0}}, (a_reg != '0)} : a_reg;
    assign cb    = rb_reg ? {{(W-1){1'b0}}, (b_reg != '0)} : b_reg;
    assign lt_ab = ($signed(ca) < $signed(cb));
    assign lt_ba = ($signed(cb) < $signed(ca));

    always_comb begin
        res_w    = '0;
        res_bool = 1'b0;
        res_err  = 1'b0;
        unique case (op_reg)
            OP_ADD: res_w = a_reg + b_reg;
            OP_SUB: res_w = a_reg - b_reg;
            OP_MUL: res_w = prod_reg;
            OP_DIV: begin
                if (b_reg == '0) begin
                    res_err = 1'b1;
                end else if (a_reg[W-1] != b_reg[W-1]) begin
                    res_w = ~quo_reg + 1'b1;
                end else begin
                    res_w = quo_reg;
                end
            end
            OP_MOD: begin
                if (b_reg == '0) begin
                    res_err = 1'b1;
                end else if (a_reg[W-1]) begin
                    res_w = ~rem_reg + 1'b1;
                end else begin
                    res_w = rem_reg;
                end
            end
            OP_POW: begin
                if (!b_reg[W-1]) begin
                    res_w = acc_reg;
                end else if (a_reg == '0) begin
                    res_err = 1'b1;
                end else if (a_reg == W'(1)) begin
                    res_w = W'(1);
                end else if (a_reg == '1) begin
                    res_w = b_reg[0] ? '1 : W'(1);
                end
            end
            OP_EQ: begin
                res_w    = {{(W-1){1'b0}}, (ca == cb)};
                res_bool = 1'b1;
            end
            OP_NE: begin
                res_w    = {{(W-1){1'b0}}, (ca != cb)};
                res_bool = 1'b1;
            end
            OP_GT: begin
                res_w    = {{(W-1){1'b0}}, lt_ba};
                res_bool = 1'b1;
            end
            OP_GE: begin
                res_w    = {{(W-1){1'b0}}, !lt_ab};
                res_bool = 1'b1;
            end
            OP_LT: begin
                res_w    = {{(W-1){1'b0}}, lt_ab};
                res_bool = 1'b1;
            end
            OP_LE: begin
                res_w    = {{(W-1){1'b0}}, !lt_ba};
                res_bool = 1'b1;
            end
            default: res_err = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_out_reg  <= VAL_W'(res_w);
            bool_out_reg <= res_bool;
            err_out_reg  <= res_err;
        end
    end

    assign m_result_value   = res_out_reg;
    assign m_result_is_bool = bool_out_reg;
    assign m_error          = err_out_reg;

endmodule

`default_nettype wire

/* hw/rtl/interpreter_integer_alu_unit.sv */
// ----------------------------------------------------------------------------
// interpreter_integer_alu_unit
// Signed integer ALU of a script interpreter with divide and power loops.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload
//  --------+-----------+-----------------------------------------------------
//  s_      | in        | op, left/right value in tdata; is_bool flags in tuser
//  m_      | out       | result value in tdata; is_bool and error in tuser
//
//  One beat at a time: s_tready is high only while the sequencer is idle. Add,
//  subtract, comparisons and error cases pass through the start and done states
//  to the result register. Multiply adds its digit-serial loop, divide and
//  modulo add the restoring divide loop, and power adds its loop of check,
//  multiply and square steps. Synchronous reset idles the sequencer and clears
//  the result valid flag. A result waiting in the output register does not block
//  the next beat; only a second finished result holds the sequencer in its final
//  state.
//
`timescale 1ns / 1ps
`default_nettype none

module interpreter_integer_alu_unit #(
    parameter int DATA_WIDTH = iiau_pkg::DATA_WIDTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Bits from lowest: op[3:0], left_value[35:4], right_value[67:36], zero pad.
    input  wire  [iiau_pkg::S_TDATA_W-1:0]   s_tdata,
    // Bits from lowest: left_is_bool, right_is_bool.
    input  wire  [iiau_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // Bits from lowest: result_value[31:0].
    output logic [iiau_pkg::M_TDATA_W-1:0]   m_tdata,
    // Bits from lowest: result_is_bool, error.
    output logic [iiau_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready
);
    import iiau_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    logic       result_is_bool, error_flag;

    // The sequencer owns both handshakes; the datapath only follows commands.
    iiau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The operands are unpacked straight from the input beat and captured in
    // the datapath in the cycle the beat is accepted.
    iiau_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk             (aclk),
        .s_op             (s_tdata[OP_W-1:0]),
        .s_left_value     (s_tdata[OP_W+VAL_W-1:OP_W]),
        .s_left_is_bool   (s_tuser[0]),
        .s_right_value    (s_tdata[OP_W+2*VAL_W-1:OP_W+VAL_W]),
        .s_right_is_bool  (s_tuser[1]),
        .cmd              (cmd),
        .stat             (stat),
        .m_result_value   (m_tdata),
        .m_result_is_bool (result_is_bool),
        .m_error          (error_flag)
    );

    assign m_tuser = {error_flag, result_is_bool};

endmodule

`default_nettype wire

/* hw/rtl/iiau_checker.sv */
// ----------------------------------------------------------------------------
// iiau_checker
// Port-level checks on the integer ALU unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "interpreter_integer_alu_unit_defines.svh"

module iiau_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire [iiau_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire [iiau_pkg::M_TUSER_W-1:0]  m_tuser,
    input wire                            m_tvalid,
    input wire                            m_tready
);
    import iiau_pkg::*;

    // A stalled result beat keeps its payload.
    `IIAU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // Comparison results are exactly zero or one.
    `IIAU_ASSERT_SAME(a_bool_range, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[M_TDATA_W-1:1] == '0, "boolean result out of range")

    // Error results carry a zero value and are never booleans.
    `IIAU_ASSERT_SAME(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[1], (m_tdata == '0) && !m_tuser[0], "error result not cleared")

    // One item is in flight at a time: accepting closes the input side.
    `IIAU_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted while busy")

endmodule

bind interpreter_integer_alu_unit iiau_checker u_iiau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the interpreter integer ALU unit.
//
// Each operation beat goes in on the s_ stream and one result beat comes
// out on the m_ stream. A short table of corner cases runs first. Some of its
// rows carry a hand-typed expected result and the rest use the bench's own
// model of the ALU. A long random run follows, checked against the same
// model. Both sides of the stream insert random gaps in three phases: a
// slow receiver, then a slow sender, then no gaps at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import iiau_pkg::*;

    localparam int          VW            = VAL_W;
    localparam int          RANDOM_BEATS  = 1600;
    localparam int          DRAIN_CYCLES  = 400;    // longer than the slowest power loop
    localparam int          STALL_LIMIT   = 20000;  // cycles without any handshake
    localparam logic [VW-1:0] INT_MIN     = 32'h8000_0000;
    localparam logic [VW-1:0] INT_MAX     = 32'h7FFF_FFFF;
    localparam logic [VW-1:0] NEG_ONE     = 32'hFFFF_FFFF;
    // Op codes 12 to 15 are not assigned; the ALU answers them with an error.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd12;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    // One result beat, unpacked from m_tdata and m_tuser.
    typedef struct {
        logic [VW-1:0] value;
        logic          is_bool;
        logic          err;
    } alu_result_t;

    // One row of the directed table. When known is set, the expected result
    // is written out in the row; otherwise the ALU model supplies it.
    typedef struct {
        logic [OP_W-1:0] op;
        logic [VW-1:0]   lhs;
        logic            lhs_bool;
        logic [VW-1:0]   rhs;
        logic            rhs_bool;
        bit              known;
        logic [VW-1:0]   want_value;
        logic            want_bool;
        logic            want_err;
    } alu_case_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // Percent chance of a gap in a given cycle, per side.
    int unsigned send_gap_pct = 17;
    int unsigned recv_gap_pct = 67;

    alu_result_t pending_results[$];
    int unsigned failures    = 0;
    int unsigned quiet_count = 0;

    interpreter_integer_alu_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // ALU model. Everything is two's complement at 32 bits and wraps.
    // ------------------------------------------------------------------------

    // Power by squaring. A negative exponent yields the truncated reciprocal,
    // which is only nonzero for a base of 1 or -1; a zero base is an error.
    function automatic alu_result_t raise_power(logic [VW-1:0] base, logic [VW-1:0] expo);
        alu_result_t   r;
        logic [VW-1:0] acc;
        logic [VW-1:0] sq;
        r   = '{value: '0, is_bool: 1'b0, err: 1'b0};
        acc = 1;
        sq  = base;
        if (expo[VW-1]) begin
            if (base == 0) begin
                r.err = 1'b1;
            end else if (base == 1) begin
                r.value = 1;
            end else if (base == NEG_ONE) begin
                r.value = expo[0] ? NEG_ONE : 1;
            end
            return r;
        end
        for (int i = 0; i < VW; i++) begin
            if (expo[i]) begin
                acc = acc * sq;
            end
            sq = sq * sq;
        end
        r.value = acc;
        return r;
    endfunction

    function automatic alu_result_t compute_alu(logic [OP_W-1:0] op, logic [VW-1:0] lhs,
                                                logic lhs_bool, logic [VW-1:0] rhs,
                                                logic rhs_bool);
        alu_result_t   r;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
        logic [VW-1:0] mag_a;
        logic [VW-1:0] mag_b;
        r = '{value: '0, is_bool: 1'b0, err: 1'b0};
        a = lhs;
        b = rhs;
        // Comparisons fold boolean operands to 0 or 1; arithmetic ignores
        // the flags altogether.
        if (op >= OP_EQ && op <= OP_LE) begin
            if (lhs_bool) a = (a != 0) ? 1 : 0;
            if (rhs_bool) b = (b != 0) ? 1 : 0;
            r.is_bool = 1'b1;
        end
        mag_a = a[VW-1] ? -a : a;
        mag_b = b[VW-1] ? -b : b;
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: r.value = a * b;
            OP_DIV, OP_MOD: begin
                if (b == 0) begin
                    r.err = 1'b1;
                end else if (op == OP_DIV) begin
                    // Truncating divide; the quotient's sign follows the
                    // operands' signs, so MIN / -1 wraps back to MIN.
                    r.value = mag_a / mag_b;
                    if (a[VW-1] != b[VW-1]) r.value = -r.value;
                end else begin
                    // The remainder takes the sign of the dividend.
                    r.value = mag_a % mag_b;
                    if (a[VW-1]) r.value = -r.value;
                end
            end
            OP_POW: r = raise_power(a, b);
            OP_EQ:  r.value = VW'(a == b);
            OP_NE:  r.value = VW'(a != b);
            OP_GT:  r.value = VW'($signed(a) >  $signed(b));
            OP_GE:  r.value = VW'($signed(a) >= $signed(b));
            OP_LT:  r.value = VW'($signed(a) <  $signed(b));
            OP_LE:  r.value = VW'($signed(a) <= $signed(b));
            default: r.err = 1'b1;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Present one operation beat and hold it until the ALU takes it. The
    // expected result is queued at the edge where the handshake completes.
    // Entered and left at a falling edge; each step assigns s_tvalid once.
    task automatic send_operation(logic [OP_W-1:0] op, logic [VW-1:0] lhs, logic lhs_bool,
                                  logic [VW-1:0] rhs, logic rhs_bool, alu_result_t want);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {{(S_TDATA_W - OP_W - 2 * VW){1'b0}}, rhs, lhs, op};
        s_tuser  <= {rhs_bool, lhs_bool};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(want);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every queued result has come back.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Operands weighted toward the edges of the signed range and small values.
    function automatic logic [VW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return 0;
            3:       return NEG_ONE;
            4, 5, 6: return VW'($signed($urandom_range(0, 32)) - 16);
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed corner cases.
    // ------------------------------------------------------------------------
    alu_case_t corner_cases[] = '{
        // Wrap on add, with both boolean flags set to show arithmetic ignores them.
        '{OP_ADD, INT_MAX, 1'b1, 32'd1, 1'b1, 1'b1, INT_MIN, 1'b0, 1'b0},
        '{OP_SUB, INT_MIN, 1'b0, 32'd1, 1'b0, 1'b1, INT_MAX, 1'b0, 1'b0},
        '{OP_MUL, INT_MAX, 1'b0, INT_MAX, 1'b0, 1'b1, 32'd1, 1'b0, 1'b0},
        '{OP_MUL, NEG_ONE, 1'b0, INT_MIN, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        // Zero divisor on both divide and modulo.
        '{OP_DIV, 32'd7, 1'b0, 32'd0, 1'b0, 1'b1, 32'd0, 1'b0, 1'b1},
        '{OP_MOD, 32'd7, 1'b0, 32'd0, 1'b0, 1'b1, 32'd0, 1'b0, 1'b1},
        // Minimum over minus one.
        '{OP_DIV, INT_MIN, 1'b0, NEG_ONE, 1'b0, 1'b1, INT_MIN, 1'b0, 1'b0},
        '{OP_MOD, INT_MIN, 1'b0, NEG_ONE, 1'b0, 1'b1, 32'd0, 1'b0, 1'b0},
        // Truncation toward zero.
        '{OP_DIV, -32'sd7, 1'b0, 32'd2, 1'b0, 1'b1, -32'sd3, 1'b0, 1'b0},
        '{OP_MOD, -32'sd7, 1'b0, 32'd2, 1'b0, 1'b1, NEG_ONE, 1'b0, 1'b0},
        // Power: zero to the zero, and the negative-exponent cases.
        '{OP_POW, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1, 32'd1, 1'b0, 1'b0},
        '{OP_POW, 32'd0, 1'b0, NEG_ONE, 1'b0, 1'b1, 32'd0, 1'b0, 1'b1},
        '{OP_POW, 32'd1, 1'b0, -32'sd5, 1'b0, 1'b1, 32'd1, 1'b0, 1'b0},
        '{OP_POW, NEG_ONE, 1'b0, -32'sd3, 1'b0, 1'b1, NEG_ONE, 1'b0, 1'b0},
        '{OP_POW, NEG_ONE, 1'b0, -32'sd4, 1'b0, 1'b1, 32'd1, 1'b0, 1'b0},
        '{OP_POW, 32'd2, 1'b0, NEG_ONE, 1'b0, 1'b1, 32'd0, 1'b0, 1'b0},
        // Longest exponent the loop can see, and a negative base.
        '{OP_POW, 32'd3, 1'b0, INT_MAX, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{OP_POW, -32'sd2, 1'b0, 32'd31, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        // Comparisons, with boolean operands folded to 0 or 1.
        '{OP_EQ, 32'd5, 1'b1, 32'd1, 1'b1, 1'b1, 32'd1, 1'b1, 1'b0},
        '{OP_NE, 32'd0, 1'b1, INT_MIN, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{OP_GT, INT_MAX, 1'b0, INT_MIN, 1'b0, 1'b1, 32'd1, 1'b1, 1'b0},
        '{OP_GE, INT_MIN, 1'b0, INT_MAX, 1'b0, 1'b1, 32'd0, 1'b1, 1'b0},
        '{OP_LT, NEG_ONE, 1'b0, 32'd0, 1'b0, 1'b1, 32'd1, 1'b1, 1'b0},
        '{OP_LE, NEG_ONE, 1'b1, 32'd1, 1'b0, 1'b1, 32'd1, 1'b1, 1'b0},
        // Unassigned op codes.
        '{OP_UNUSED_LO, 32'd3, 1'b0, 32'd4, 1'b0, 1'b1, 32'd0, 1'b0, 1'b1},
        '{OP_UNUSED_HI, NEG_ONE, 1'b1, NEG_ONE, 1'b1, 1'b1, 32'd0, 1'b0, 1'b1}
    };

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, three random phases, drain.
    // ------------------------------------------------------------------------
    initial begin
        alu_case_t       row;
        alu_result_t     want;
        logic [OP_W-1:0] op;
        logic [VW-1:0]   lhs;
        logic [VW-1:0]   rhs;
        logic            lhs_bool;
        logic            rhs_bool;
        int unsigned     phase;
        int unsigned     last_phase;

        // Reset is held at the start and released at a falling edge, so
        // the first beat is driven well clear of the edge that samples it.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (corner_cases[i]) begin
            row = corner_cases[i];
            if (row.known) begin
                want = '{value: row.want_value, is_bool: row.want_bool, err: row.want_err};
            end else begin
                want = compute_alu(row.op, row.lhs, row.lhs_bool, row.rhs, row.rhs_bool);
            end
            send_operation(row.op, row.lhs, row.lhs_bool, row.rhs, row.rhs_bool, want);
        end

        // The sender holds off here until the pipe is empty.
        wait_for_drain();

        last_phase = 0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            phase = (n * 3) / RANDOM_BEATS;
            if (phase != last_phase) begin
                wait_for_drain();
                // Second phase swaps the gap rates; the last one has no gaps.
                send_gap_pct = (phase == 1) ? 67 : 0;
                recv_gap_pct = (phase == 1) ? 17 : 0;
                last_phase   = phase;
            end

            // Mostly defined ops, with an occasional unassigned code.
            if ($urandom_range(0, 99) < 4) begin
                op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end else begin
                op = OP_W'($urandom_range(OP_ADD, OP_LE));
            end
            lhs      = pick_operand();
            rhs      = pick_operand();
            lhs_bool = 1'($urandom_range(0, 1));
            rhs_bool = 1'($urandom_range(0, 1));

            if (op == OP_POW && $urandom_range(0, 9) < 7) begin
                // Small bases and exponents give results that do not all
                // wrap to zero, which exercises the multiply chain properly.
                lhs = VW'($signed($urandom_range(0, 8)) - 4);
                rhs = VW'($signed($urandom_range(0, 43)) - 3);
            end else if (op >= OP_EQ && op <= OP_LE && $urandom_range(0, 2) == 0) begin
                // Boolean-looking operands, and sometimes equal operands.
                lhs = $urandom_range(0, 1);
                rhs = $urandom_range(0, 1) ? lhs : VW'($urandom_range(0, 1));
            end else if ((op == OP_DIV || op == OP_MOD) && $urandom_range(0, 3) == 0) begin
                // Small divisors give nontrivial quotients and remainders.
                rhs = VW'($signed($urandom_range(0, 20)) - 10);
            end

            want = compute_alu(op, lhs, lhs_bool, rhs, rhs_bool);
            send_operation(op, lhs, lhs_bool, rhs, rhs_bool, want);
        end

        wait_for_drain();
        // Give a stray extra result time to show up before closing.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            failures++;
        end
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // The receiver decides its ready at every falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    // ------------------------------------------------------------------------
    // Result checker. Each accepted result beat is compared field by field
    // with the oldest queued expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        alu_result_t want;
        alu_result_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen = '{value: m_tdata[VW-1:0], is_bool: m_tuser[0], err: m_tuser[1]};
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: value %0d", $signed(seen.value));
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (seen.value !== want.value) begin
                    $error("result_value: expected %0d, got %0d",
                           $signed(want.value), $signed(seen.value));
                    failures++;
                end
                if (seen.is_bool !== want.is_bool) begin
                    $error("result_is_bool: expected %0b, got %0b", want.is_bool, seen.is_bool);
                    failures++;
                end
                if (seen.err !== want.err) begin
                    $error("error: expected %0b, got %0b", want.err, seen.err);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a long stretch with no handshake on either side means the
    // ALU has hung.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
            if (quiet_count >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/iiau_pkg.sv
hw/rtl/iiau_ctrl.sv
hw/rtl/iiau_dp.sv
hw/rtl/interpreter_integer_alu_unit.sv
hw/rtl/iiau_checker.sv
tb/testbench.sv
